>>> rtl/core/tfn_pkg.sv
package tfn_pkg;

   // Default sizes of the ports.
   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int INDEX_BITS_DEF       = 16;

   // Normalized magnitudes keep their largest component in [2^29, 2^30).
   localparam int NORM_MSB  = 29;
   localparam int NORM_BITS = 30;
   // Sum of three squares of 30-bit values, and its integer square root.
   localparam int SUM_BITS  = 62;
   localparam int ROOT_BITS = 31;
   // Edge components are cut to at most this many magnitude bits.
   localparam int EDGE_LIMIT = 30;

   // Beat codes of the result serializer.
   localparam logic [1:0] BEAT_A = 2'd0;
   localparam logic [1:0] BEAT_B = 2'd1;
   localparam logic [1:0] BEAT_C = 2'd2;

   typedef struct packed {
      logic [2:0] neg;
      logic       degen;
   } tri_flags_type;

   // Signed width of one edge component after the range cut.
   function automatic int edge_bits(input int coord_bits);
      return (coord_bits > EDGE_LIMIT) ? EDGE_LIMIT + 1 : coord_bits + 1;
   endfunction

endpackage

>>> rtl/core/tfn_cross.sv
module tfn_cross #(
   parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF,
   parameter int SIDE_W     = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [8:0][COORD_BITS-1:0]            coord,
   input  logic [SIDE_W-1:0]                     side_in,
   output logic                                  out_valid,
   output logic [2:0][2*tfn_pkg::edge_bits(COORD_BITS)-1:0] mag,
   output logic [2:0]                            neg,
   output logic [SIDE_W-1:0]                     side_out
);
   import tfn_pkg::*;

   localparam int EB  = edge_bits(COORD_BITS);
   localparam int MW  = 2 * EB;
   localparam int RSH = (COORD_BITS > EDGE_LIMIT) ? COORD_BITS - EDGE_LIMIT : 0;

   logic [2:0]                 valid_ff;
   logic signed [5:0][EB-1:0]  edge_ff;
   logic signed [5:0][EB-1:0]  edge_in;
   logic signed [5:0][MW-1:0]  prod_ff;
   logic [2:0][MW-1:0]         mag_ff;
   logic [2:0]                 neg_ff;
   logic [SIDE_W-1:0]          side1_ff, side2_ff, side3_ff;

   // Edges e1 = b - a (slots 0..2) and e2 = c - a (slots 3..5).
   always_comb begin
      logic signed [COORD_BITS:0] d;
      logic [COORD_BITS:0]        dm;
      logic [COORD_BITS:0]        dr;
      logic signed [COORD_BITS:0] ds;
      for (int k = 0; k < 6; k++) begin
         d  = $signed({coord[3 + k][COORD_BITS-1], coord[3 + k]})
            - $signed({coord[k % 3][COORD_BITS-1], coord[k % 3]});
         dm = d[COORD_BITS] ? COORD_BITS'(0) - d : d;
         dr = dm >> RSH;
         ds = d[COORD_BITS] ? -$signed(dr) : $signed(dr);
         edge_in[k] = ds[EB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // Elements of a packed array are unsigned, so each factor is made signed.
   always_ff @(posedge clock) begin
      logic signed [MW:0] cr;
      if (en) begin
         edge_ff  <= edge_in;
         side1_ff <= side_in;
         prod_ff[0] <= $signed(edge_ff[1]) * $signed(edge_ff[5]);
         prod_ff[1] <= $signed(edge_ff[2]) * $signed(edge_ff[4]);
         prod_ff[2] <= $signed(edge_ff[2]) * $signed(edge_ff[3]);
         prod_ff[3] <= $signed(edge_ff[0]) * $signed(edge_ff[5]);
         prod_ff[4] <= $signed(edge_ff[0]) * $signed(edge_ff[4]);
         prod_ff[5] <= $signed(edge_ff[1]) * $signed(edge_ff[3]);
         side2_ff <= side1_ff;
         for (int k = 0; k < 3; k++) begin
            cr = $signed({prod_ff[2*k][MW-1], prod_ff[2*k]})
               - $signed({prod_ff[2*k+1][MW-1], prod_ff[2*k+1]});
            neg_ff[k] <= cr[MW];
            mag_ff[k] <= cr[MW] ? MW'(-cr) : cr[MW-1:0];
         end
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign mag       = mag_ff;
   assign neg       = neg_ff;
   assign side_out  = side3_ff;

endmodule

>>> rtl/core/tfn_scale.sv
module tfn_scale #(
   parameter int MW     = 34,
   parameter int SIDE_W = 48
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  logic                                       in_valid,
   input  logic [2:0][MW-1:0]                         mag,
   input  logic [2:0]                                 neg,
   input  logic [SIDE_W-1:0]                          side_in,
   output logic                                       out_valid,
   output logic [tfn_pkg::SUM_BITS-1:0]               sum,
   output logic [2:0][tfn_pkg::NORM_BITS-1:0]         nmag,
   output tfn_pkg::tri_flags_type                     flags,
   output logic [SIDE_W-1:0]                          side_out
);
   import tfn_pkg::*;

   localparam int NG = (MW + 7) / 8;
   localparam int PW = $clog2(MW);
   localparam int WW = MW + NORM_MSB;

   logic [5:0]             valid_ff;
   logic [2:0][MW-1:0]     mag4_ff, mag5_ff, mag6_ff;
   logic [MW-1:0]          max4_ff;
   logic [NG-1:0]          nz_ff;
   logic [NG-1:0][2:0]     lp_ff;
   logic [PW-1:0]          pos_ff;
   logic [PW-1:0]          pos_in;
   tri_flags_type          fl4_ff, fl5_ff, fl6_ff, fl7_ff, fl8_ff, fl9_ff;
   logic [2:0][NORM_BITS-1:0] sh7_ff, sh8_ff, sh9_ff;
   logic [2:0][2*NORM_BITS-1:0] sq_ff;
   logic [SUM_BITS-1:0]    sum_ff;
   logic [SIDE_W-1:0]      sd4_ff, sd5_ff, sd6_ff, sd7_ff, sd8_ff, sd9_ff;

   always_comb begin
      pos_in = '0;
      for (int g = 0; g < NG; g++) begin
         if (nz_ff[g]) begin
            pos_in = PW'(g * 8) + PW'(lp_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [MW-1:0]      mx;
      logic [NG*8-1:0]    pad;
      logic [WW-1:0]      wide;
      logic [2:0]         lp;
      if (en) begin
         // Largest magnitude.
         mx = (mag[0] > mag[1]) ? mag[0] : mag[1];
         mx = (mx > mag[2]) ? mx : mag[2];
         max4_ff      <= mx;
         mag4_ff      <= mag;
         fl4_ff.neg   <= neg;
         fl4_ff.degen <= (mx == '0);
         sd4_ff       <= side_in;
         // Leading one per byte group.
         pad = (NG*8)'(max4_ff);
         for (int g = 0; g < NG; g++) begin
            nz_ff[g] <= |pad[g*8 +: 8];
            lp = 3'd0;
            for (int b = 0; b < 8; b++) begin
               if (pad[g*8 + b]) begin
                  lp = 3'(b);
               end
            end
            lp_ff[g] <= lp;
         end
         mag5_ff <= mag4_ff;
         fl5_ff  <= fl4_ff;
         sd5_ff  <= sd4_ff;
         pos_ff  <= pos_in;
         mag6_ff <= mag5_ff;
         fl6_ff  <= fl5_ff;
         sd6_ff  <= sd5_ff;
         // Align so the leading one of the largest lands on bit 29.
         for (int k = 0; k < 3; k++) begin
            wide       = {mag6_ff[k], {NORM_MSB{1'b0}}} >> pos_ff;
            sh7_ff[k] <= wide[NORM_BITS-1:0];
         end
         fl7_ff <= fl6_ff;
         sd7_ff <= sd6_ff;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= sh7_ff[k] * sh7_ff[k];
         end
         sh8_ff <= sh7_ff;
         fl8_ff <= fl7_ff;
         sd8_ff <= sd7_ff;
         sum_ff <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
         sh9_ff <= sh8_ff;
         fl9_ff <= fl8_ff;
         sd9_ff <= sd8_ff;
      end
   end

   assign out_valid = valid_ff[5];
   assign sum       = sum_ff;
   assign nmag      = sh9_ff;
   assign flags     = fl9_ff;
   assign side_out  = sd9_ff;

endmodule

>>> rtl/core/tfn_isqrt.sv
module tfn_isqrt #(
   parameter int SIDE_W = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [tfn_pkg::SUM_BITS-1:0]      radicand,
   input  logic [SIDE_W-1:0]                 side_in,
   output logic                              out_valid,
   output logic [tfn_pkg::ROOT_BITS-1:0]     root,
   output logic [SIDE_W-1:0]                 side_out
);
   import tfn_pkg::*;

   localparam int RW = SUM_BITS + 1;

   logic [ROOT_BITS-1:0]          valid_ff;
   logic [ROOT_BITS-1:0][RW-1:0]  rem_ff;
   logic [ROOT_BITS-1:0][RW-1:0]  root_ff;
   logic [ROOT_BITS-1:0][SIDE_W-1:0] side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_BITS-2:0], in_valid};
      end
   end

   // One result bit per stage, starting from the weight 4^30.
   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_step
      localparam logic [RW-1:0] WEIGHT = RW'(1) << (2 * (ROOT_BITS - 1 - g));
      logic [RW-1:0] rem_cur, root_cur, trial;
      logic [SIDE_W-1:0] side_cur;
      if (g == 0) begin : g_first
         assign rem_cur  = RW'(radicand);
         assign root_cur = '0;
         assign side_cur = side_in;
      end else begin : g_next
         assign rem_cur  = rem_ff[g-1];
         assign root_cur = root_ff[g-1];
         assign side_cur = side_ff[g-1];
      end
      assign trial = root_cur + WEIGHT;
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[g] <= side_cur;
            if (rem_cur >= trial) begin
               rem_ff[g]  <= rem_cur - trial;
               root_ff[g] <= (root_cur >> 1) + WEIGHT;
            end else begin
               rem_ff[g]  <= rem_cur;
               root_ff[g] <= root_cur >> 1;
            end
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign root      = root_ff[ROOT_BITS-1][ROOT_BITS-1:0];
   assign side_out  = side_ff[ROOT_BITS-1];

endmodule

>>> rtl/core/tfn_div.sv
module tfn_div #(
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
   parameter int SIDE_W           = 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic [tfn_pkg::ROOT_BITS-1:0]         len,
   input  logic [2:0][tfn_pkg::NORM_BITS-1:0]    nmag,
   input  logic [SIDE_W-1:0]                     side_in,
   output logic                                  out_valid,
   output logic [2:0][NORMAL_FRAC_BITS:0]        quot,
   output logic [SIDE_W-1:0]                     side_out
);
   import tfn_pkg::*;

   localparam int QB = NORMAL_FRAC_BITS + 1;
   localparam int DW = ROOT_BITS + NORMAL_FRAC_BITS;

   logic                        v0_ff;
   logic [2:0][DW-1:0]          num0_ff;
   logic [ROOT_BITS-1:0]        len0_ff;
   logic [SIDE_W-1:0]           side0_ff;

   logic [QB-1:0]               valid_ff;
   logic [QB-1:0][2:0][DW-1:0]  rem_ff;
   logic [QB-1:0][2:0][QB-1:0]  q_ff;
   logic [QB-1:0][ROOT_BITS-1:0] len_ff;
   logic [QB-1:0][SIDE_W-1:0]   side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         valid_ff <= '0;
      end else if (en) begin
         v0_ff    <= in_valid;
         valid_ff <= {valid_ff[QB-2:0], v0_ff};
      end
   end

   // Rounded numerator: mag * 2^F + floor(len / 2).
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            num0_ff[k] <= (DW'(nmag[k]) << NORMAL_FRAC_BITS) + DW'(len >> 1);
         end
         len0_ff  <= len;
         side0_ff <= side_in;
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   for (genvar j = 0; j < QB; j++) begin : g_step
      localparam int SH = QB - 1 - j;
      logic [2:0][DW-1:0] rem_cur;
      logic [2:0][QB-1:0] q_cur;
      logic [ROOT_BITS-1:0] len_cur;
      logic [SIDE_W-1:0]  side_cur;
      logic [DW-1:0]      dvs;
      if (j == 0) begin : g_first
         assign rem_cur  = num0_ff;
         assign q_cur    = '0;
         assign len_cur  = len0_ff;
         assign side_cur = side0_ff;
      end else begin : g_next
         assign rem_cur  = rem_ff[j-1];
         assign q_cur    = q_ff[j-1];
         assign len_cur  = len_ff[j-1];
         assign side_cur = side_ff[j-1];
      end
      assign dvs = DW'(len_cur) << SH;
      always_ff @(posedge clock) begin
         if (en) begin
            len_ff[j]  <= len_cur;
            side_ff[j] <= side_cur;
            for (int k = 0; k < 3; k++) begin
               if (rem_cur[k] >= dvs) begin
                  rem_ff[j][k] <= rem_cur[k] - dvs;
                  q_ff[j][k]   <= {q_cur[k][QB-2:0], 1'b1};
               end else begin
                  rem_ff[j][k] <= rem_cur[k];
                  q_ff[j][k]   <= {q_cur[k][QB-2:0], 1'b0};
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign quot      = q_ff[QB-1];
   assign side_out  = side_ff[QB-1];

endmodule

>>> rtl/core/triangle_face_normal_unit.sv
// Flat face normal of one triangle. Each request transaction carries three
// vertex positions in signed fixed point and three vertex indices; the unit
// forms the edges b - a and c - a, takes their cross product and scales it to
// unit length with NORMAL_FRAC_BITS fraction bits (rounded, clamped to 1.0).
// Each triangle yields three response transactions, one per vertex index in
// the order a, b, c, all carrying the same normal, with last_of_triangle set
// on the third. A zero cross product gives a zero normal and sets degenerate.
// A request is accepted every cycle while the pipeline moves; the sustained
// rate is limited by the single response channel, which sends three beats
// per triangle. From acceptance to the first response a request passes
// through the cross product, alignment and sum of squares, a 31-stage square
// root, a rounding stage plus one quotient bit per stage, and the output
// register. The whole pipeline holds while its last stage waits for the
// serializer.
module triangle_face_normal_unit #(
   parameter int COORD_BITS       = tfn_pkg::COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF,
   parameter int INDEX_BITS       = tfn_pkg::INDEX_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_BITS-1:0]      req_a_x,
   input  logic signed [COORD_BITS-1:0]      req_a_y,
   input  logic signed [COORD_BITS-1:0]      req_a_z,
   input  logic signed [COORD_BITS-1:0]      req_b_x,
   input  logic signed [COORD_BITS-1:0]      req_b_y,
   input  logic signed [COORD_BITS-1:0]      req_b_z,
   input  logic signed [COORD_BITS-1:0]      req_c_x,
   input  logic signed [COORD_BITS-1:0]      req_c_y,
   input  logic signed [COORD_BITS-1:0]      req_c_z,
   input  logic [INDEX_BITS-1:0]             req_a_index,
   input  logic [INDEX_BITS-1:0]             req_b_index,
   input  logic [INDEX_BITS-1:0]             req_c_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [INDEX_BITS-1:0]             rsp_vertex_index,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_x,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_y,
   output logic signed [NORMAL_FRAC_BITS+1:0] rsp_normal_z,
   output logic                              rsp_degenerate,
   output logic                              rsp_last_of_triangle
);
   import tfn_pkg::*;

   localparam int EB    = edge_bits(COORD_BITS);
   localparam int MW    = 2 * EB;
   localparam int IDX_W = 3 * INDEX_BITS;
   localparam int FL_W  = $bits(tri_flags_type);
   localparam int SQ_W  = FL_W + 3 * NORM_BITS + IDX_W;
   localparam int DV_W  = FL_W + IDX_W;
   localparam int NB    = NORMAL_FRAC_BITS + 2;
   localparam int QB    = NORMAL_FRAC_BITS + 1;

   // Global advance: every stage moves unless the last one holds a triangle
   // that the serializer cannot take yet.
   logic en;
   logic ser_free;

   logic                    cr_valid;
   logic [2:0][MW-1:0]      cr_mag;
   logic [2:0]              cr_neg;
   logic [IDX_W-1:0]        cr_idx;

   logic                    sc_valid;
   logic [SUM_BITS-1:0]     sc_sum;
   logic [2:0][NORM_BITS-1:0] sc_nmag;
   tri_flags_type           sc_flags;
   logic [IDX_W-1:0]        sc_idx;

   logic                    sq_valid;
   logic [ROOT_BITS-1:0]    sq_root;
   logic [SQ_W-1:0]         sq_side;
   tri_flags_type           sq_flags;
   logic [2:0][NORM_BITS-1:0] sq_nmag;
   logic [IDX_W-1:0]        sq_idx;

   logic                    dv_valid;
   logic [2:0][QB-1:0]      dv_quot;
   logic [DV_W-1:0]         dv_side;
   tri_flags_type           dv_flags;
   logic [IDX_W-1:0]        dv_idx;

   logic [2:0][NB-1:0]      norm_in;
   logic                    load;

   logic                    out_valid_ff;
   logic [1:0]              beat_ff;
   logic [2:0][NB-1:0]      norm_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    degen_ff;

   assign ser_free  = !out_valid_ff || (beat_ff == BEAT_C && !rsp_stall);
   assign en        = ser_free || !dv_valid;
   assign req_stall = !en;
   assign load      = dv_valid && ser_free;

   tfn_cross #(
      .COORD_BITS (COORD_BITS),
      .SIDE_W     (IDX_W)
   ) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .coord     ({req_c_z, req_c_y, req_c_x, req_b_z, req_b_y, req_b_x,
                   req_a_z, req_a_y, req_a_x}),
      .side_in   ({req_c_index, req_b_index, req_a_index}),
      .out_valid (cr_valid),
      .mag       (cr_mag),
      .neg       (cr_neg),
      .side_out  (cr_idx)
   );

   tfn_scale #(
      .MW     (MW),
      .SIDE_W (IDX_W)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cr_valid),
      .mag       (cr_mag),
      .neg       (cr_neg),
      .side_in   (cr_idx),
      .out_valid (sc_valid),
      .sum       (sc_sum),
      .nmag      (sc_nmag),
      .flags     (sc_flags),
      .side_out  (sc_idx)
   );

   tfn_isqrt #(
      .SIDE_W (SQ_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid),
      .radicand  (sc_sum),
      .side_in   ({sc_flags, sc_nmag, sc_idx}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   assign {sq_flags, sq_nmag, sq_idx} = sq_side;

   tfn_div #(
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
      .SIDE_W           (DV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .len       (sq_root),
      .nmag      (sq_nmag),
      .side_in   ({sq_flags, sq_idx}),
      .out_valid (dv_valid),
      .quot      (dv_quot),
      .side_out  (dv_side)
   );

   assign {dv_flags, dv_idx} = dv_side;

   // Clamp to 1.0, apply the sign, and force zero for a degenerate triangle.
   always_comb begin
      logic [QB-1:0] q;
      for (int k = 0; k < 3; k++) begin
         q = (dv_quot[k] > (QB'(1) << NORMAL_FRAC_BITS))
           ? (QB'(1) << NORMAL_FRAC_BITS) : dv_quot[k];
         if (dv_flags.degen) begin
            norm_in[k] = '0;
         end else if (dv_flags.neg[k]) begin
            norm_in[k] = NB'(0) - NB'(q);
         end else begin
            norm_in[k] = NB'(q);
         end
      end
   end

   // Output register: holds one triangle and sends it as three transactions.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= BEAT_A;
      end else if (load) begin
         out_valid_ff <= 1'b1;
         beat_ff      <= BEAT_A;
      end else if (out_valid_ff && !rsp_stall) begin
         case (beat_ff)
            BEAT_A:  beat_ff <= BEAT_B;
            BEAT_B:  beat_ff <= BEAT_C;
            BEAT_C:  out_valid_ff <= 1'b0;
            default: out_valid_ff <= 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         norm_ff  <= norm_in;
         idx_ff   <= dv_idx;
         degen_ff <= dv_flags.degen;
      end
   end

   always_comb begin
      case (beat_ff)
         BEAT_A:  rsp_vertex_index = idx_ff[0 +: INDEX_BITS];
         BEAT_B:  rsp_vertex_index = idx_ff[INDEX_BITS +: INDEX_BITS];
         BEAT_C:  rsp_vertex_index = idx_ff[2*INDEX_BITS +: INDEX_BITS];
         default: rsp_vertex_index = idx_ff[0 +: INDEX_BITS];
      endcase
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_normal_x         = norm_ff[0];
   assign rsp_normal_y         = norm_ff[1];
   assign rsp_normal_z         = norm_ff[2];
   assign rsp_degenerate       = degen_ff;
   assign rsp_last_of_triangle = (beat_ff == BEAT_C);

endmodule
